// ===== rtl/core/iop_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 option parser package
// Shared types, option codes and record kinds for the option area parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iop_pkg;

    // Largest option area the parser accepts; longer lengths are clamped.
    localparam int unsigned MAX_OPTION_BYTES = 40;

    // Option type codes.
    localparam logic [7:0] OPT_EOL  = 8'd0;
    localparam logic [7:0] OPT_NOP  = 8'd1;
    localparam logic [7:0] OPT_RR   = 8'd7;
    localparam logic [7:0] OPT_TS   = 8'd68;
    localparam logic [7:0] OPT_LSRR = 8'd131;
    localparam logic [7:0] OPT_SSRR = 8'd137;

    // Timestamp flag byte masks.
    localparam logic [7:0] TS_BAD_FLAGS = 8'h0C;
    localparam logic [7:0] TS_ADDR_MASK = 8'h03;

    // Record kinds.
    localparam logic [2:0] KIND_HEADER     = 3'd0;
    localparam logic [2:0] KIND_ROUTE_ADDR = 3'd1;
    localparam logic [2:0] KIND_STAMP      = 3'd2;
    localparam logic [2:0] KIND_STAMP_ADDR = 3'd3;
    localparam logic [2:0] KIND_RAW        = 3'd4;
    localparam logic [2:0] KIND_DONE       = 3'd5;

    // Parse phase, one-hot.
    typedef enum logic [5:0] {
        PH_TYPE  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_PTR   = 6'b000100,
        PH_FLAGS = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_RAW   = 6'b100000
    } phase_t;

    // One result record.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  type_code;
        logic [5:0]  option_length;
        logic [7:0]  pointer_value;
        logic [3:0]  stamp_flags;
        logic [31:0] data_word;
        logic        area_error;
        logic        last_record;
    } rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/iop_parse.sv =====
// ----------------------------------------------------------------------------
// IPv4 option parser state and record generation
// Holds the parse state and works out, for one option byte, the records it
// causes: at most one option record followed by at most one area done record.
// ----------------------------------------------------------------------------
`default_nettype none

module iop_parse #(
    parameter int unsigned MAX_OPTION_BYTES = iop_pkg::MAX_OPTION_BYTES
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            byte_fire,
    input  wire logic [7:0]      opt_byte,
    input  wire logic            area_start,
    input  wire logic [5:0]      area_length,
    output iop_pkg::rec_t        rec_a,
    output logic                 rec_a_valid,
    output iop_pkg::rec_t        rec_b,
    output logic                 rec_b_valid
);
    import iop_pkg::*;

    // Parse state registers.
    logic [5:0]  pos_reg,   pos_next;
    logic [5:0]  size_reg,  size_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg,  type_next;
    logic [7:0]  len_reg,   len_next;
    logic [5:0]  ostart_reg, ostart_next;
    logic [7:0]  ptr_reg,   ptr_next;
    logic [3:0]  flags_reg, flags_next;
    logic [31:0] acc_reg,   acc_next;
    logic [1:0]  wcnt_reg,  wcnt_next;
    logic        half_reg,  half_next;
    logic        err_reg,   err_next;

    // Values the byte is parsed against (state after an area start).
    logic [5:0]  pos_e;
    logic [5:0]  size_e;
    phase_t      phase_e;
    logic [7:0]  type_e;
    logic [7:0]  len_e;
    logic [5:0]  ostart_e;
    logic [7:0]  ptr_e;
    logic [3:0]  flags_e;
    logic [31:0] acc_e;
    logic [1:0]  wcnt_e;
    logic        half_e;
    logic        err_e;

    logic [5:0]  len_clamped;
    logic        active;
    logic [8:0]  last_pos;
    logic        at_last;
    logic [8:0]  opt_end;
    logic [8:0]  ptr_limit;
    logic        is_route;
    logic [31:0] acc_shift;
    logic        opt_valid;
    logic [2:0]  opt_kind;
    logic [31:0] opt_data;
    logic        done_valid;
    rec_t        opt_rec;
    rec_t        done_rec;

    // Area length clamped into the supported range.
    always_comb begin
        if (area_length == 6'd0) begin
            len_clamped = 6'd1;
        end else if (area_length > 6'(MAX_OPTION_BYTES)) begin
            len_clamped = 6'(MAX_OPTION_BYTES);
        end else begin
            len_clamped = area_length;
        end
    end

    // An area start discards the running area and begins from reset state.
    always_comb begin
        pos_e    = area_start ? 6'd0    : pos_reg;
        size_e   = area_start ? len_clamped : size_reg;
        phase_e  = area_start ? PH_TYPE : phase_reg;
        type_e   = area_start ? 8'd0    : type_reg;
        len_e    = area_start ? 8'd0    : len_reg;
        ostart_e = area_start ? 6'd0    : ostart_reg;
        ptr_e    = area_start ? 8'd0    : ptr_reg;
        flags_e  = area_start ? 4'd0    : flags_reg;
        acc_e    = area_start ? 32'd0   : acc_reg;
        wcnt_e   = area_start ? 2'd0    : wcnt_reg;
        half_e   = area_start ? 1'b0    : half_reg;
        err_e    = area_start ? 1'b0    : err_reg;
    end

    assign active    = pos_e < size_e;
    assign last_pos  = {3'd0, ostart_e} + {1'b0, len_e} - 9'd1;
    assign at_last   = {3'd0, pos_e} == last_pos;
    assign opt_end   = {3'd0, ostart_e} + {1'b0, opt_byte};
    assign ptr_limit = {1'b0, len_e} + 9'd1;
    assign is_route  = (type_e == OPT_RR) || (type_e == OPT_LSRR) || (type_e == OPT_SSRR);
    assign acc_shift = {acc_e[23:0], opt_byte};

    // Byte parse: next state and the option record, if any.
    always_comb begin
        pos_next    = pos_e;
        size_next   = size_e;
        phase_next  = phase_e;
        type_next   = type_e;
        len_next    = len_e;
        ostart_next = ostart_e;
        ptr_next    = ptr_e;
        flags_next  = flags_e;
        acc_next    = acc_e;
        wcnt_next   = wcnt_e;
        half_next   = half_e;
        err_next    = err_e;
        opt_valid   = 1'b0;
        opt_kind    = KIND_HEADER;
        opt_data    = 32'd0;
        done_valid  = 1'b0;

        if (active && !err_e) begin
            unique case (phase_e)
                PH_TYPE: begin
                    ostart_next = pos_e;
                    type_next   = opt_byte;
                    ptr_next    = 8'd0;
                    flags_next  = 4'd0;
                    if (opt_byte == OPT_EOL || opt_byte == OPT_NOP) begin
                        len_next  = 8'd1;
                        opt_valid = 1'b1;
                    end else begin
                        len_next   = 8'd0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    len_next = opt_byte;
                    if (opt_byte < 8'd2 || opt_end > {3'd0, size_e}) begin
                        err_next = 1'b1;
                    end else if (is_route) begin
                        if (opt_byte < 8'd3 || opt_byte[1:0] != 2'd3) begin
                            err_next = 1'b1;
                        end else begin
                            phase_next = PH_PTR;
                        end
                    end else if (type_e == OPT_TS) begin
                        if (opt_byte < 8'd4 || opt_byte[1:0] != 2'd0) begin
                            err_next = 1'b1;
                        end else begin
                            phase_next = PH_PTR;
                        end
                    end else begin
                        opt_valid  = 1'b1;
                        phase_next = (opt_byte == 8'd2) ? PH_TYPE : PH_RAW;
                    end
                end
                PH_PTR: begin
                    ptr_next = opt_byte;
                    if (is_route) begin
                        if (opt_byte[1:0] != 2'd0 || opt_byte < 8'd4 ||
                            {1'b0, opt_byte} > ptr_limit) begin
                            err_next = 1'b1;
                        end else begin
                            opt_valid  = 1'b1;
                            wcnt_next  = 2'd0;
                            acc_next   = 32'd0;
                            phase_next = at_last ? PH_TYPE : PH_DATA;
                        end
                    end else begin
                        if (opt_byte[1:0] != 2'd1 || opt_byte < 8'd5 ||
                            {1'b0, opt_byte} > ptr_limit) begin
                            err_next = 1'b1;
                        end else begin
                            phase_next = PH_FLAGS;
                        end
                    end
                end
                PH_FLAGS: begin
                    if ((opt_byte & TS_BAD_FLAGS) != 8'd0 ||
                        (opt_byte & TS_ADDR_MASK) == 8'd2) begin
                        err_next = 1'b1;
                    end else if ((opt_byte & TS_ADDR_MASK) != 8'd0 &&
                                 (len_e[2:0] != 3'd4 || ptr_e[2:0] != 3'd5)) begin
                        err_next = 1'b1;
                    end else begin
                        flags_next = opt_byte[3:0];
                        opt_valid  = 1'b1;
                        half_next  = 1'b0;
                        wcnt_next  = 2'd0;
                        acc_next   = 32'd0;
                        phase_next = at_last ? PH_TYPE : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (wcnt_e == 2'd3) begin
                        opt_valid = 1'b1;
                        opt_data  = acc_shift;
                        if (is_route) begin
                            opt_kind = KIND_ROUTE_ADDR;
                        end else if (flags_e[1:0] != 2'd0) begin
                            opt_kind  = half_e ? KIND_STAMP : KIND_STAMP_ADDR;
                            half_next = ~half_e;
                        end else begin
                            opt_kind = KIND_STAMP;
                        end
                        wcnt_next = 2'd0;
                        acc_next  = 32'd0;
                    end else begin
                        wcnt_next = wcnt_e + 2'd1;
                        acc_next  = acc_shift;
                    end
                    if (at_last) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_RAW: begin
                    opt_valid = 1'b1;
                    opt_kind  = KIND_RAW;
                    opt_data  = {24'd0, opt_byte};
                    if (at_last) begin
                        phase_next = PH_TYPE;
                    end
                end
                default: begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        // End of area: an option still open is malformed.
        if (active) begin
            pos_next = pos_e + 6'd1;
            if (pos_next == size_e) begin
                if (phase_next != PH_TYPE) begin
                    err_next = 1'b1;
                end
                done_valid = 1'b1;
                phase_next = PH_TYPE;
            end
        end
    end

    // Records built from the updated option state.
    always_comb begin
        opt_rec.kind          = opt_kind;
        opt_rec.type_code     = type_next;
        opt_rec.option_length = len_next[5:0];
        opt_rec.pointer_value = ptr_next;
        opt_rec.stamp_flags   = flags_next;
        opt_rec.data_word     = opt_data;
        opt_rec.area_error    = 1'b0;
        opt_rec.last_record   = !done_valid;

        done_rec               = '0;
        done_rec.kind          = KIND_DONE;
        done_rec.area_error    = err_next;
        done_rec.last_record   = 1'b1;
    end

    // The first record of the byte always sits in slot A.
    always_comb begin
        rec_a_valid = opt_valid || done_valid;
        rec_a       = opt_valid ? opt_rec : done_rec;
        rec_b_valid = opt_valid && done_valid;
        rec_b       = done_rec;
    end

    // State update on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 6'd0;
            size_reg   <= 6'd0;
            phase_reg  <= PH_TYPE;
            type_reg   <= 8'd0;
            len_reg    <= 8'd0;
            ostart_reg <= 6'd0;
            ptr_reg    <= 8'd0;
            flags_reg  <= 4'd0;
            acc_reg    <= 32'd0;
            wcnt_reg   <= 2'd0;
            half_reg   <= 1'b0;
            err_reg    <= 1'b0;
        end else if (byte_fire) begin
            pos_reg    <= pos_next;
            size_reg   <= size_next;
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            ostart_reg <= ostart_next;
            ptr_reg    <= ptr_next;
            flags_reg  <= flags_next;
            acc_reg    <= acc_next;
            wcnt_reg   <= wcnt_next;
            half_reg   <= half_next;
            err_reg    <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_option_parser.sv =====
// The first record of a byte appears on the output in the cycle after the
// byte's transaction. One byte is taken per cycle while the output stage can
// take it; a byte that ends an area while also yielding an option record holds
// the input until its overflow record moves into the head register. Reset
// (aresetn low, synchronous) clears the parse state and empties the output
// stage.
// ----------------------------------------------------------------------------
// IPv4 option parser
// Splits an IPv4 option area, one byte per transaction, into option records
// and an area done record, behind a two-entry output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_option_parser #(
    parameter int unsigned MAX_OPTION_BYTES = iop_pkg::MAX_OPTION_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // opt_byte [7:0], area_length [13:8], zero pad
    input  wire logic        s_tuser,   // area_start [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // type_code [7:0], option_length [13:8],
                                        // pointer_value [21:14], stamp_flags [25:22],
                                        // data_word [57:26], area_error [58], zero pad
    output logic [2:0]       m_tuser,   // record_kind [2:0]
    output logic             m_tlast    // last_record
);
    import iop_pkg::*;

    logic  in_fire;
    logic  out_fire;
    rec_t  rec_a;
    rec_t  rec_b;
    logic  rec_a_valid;
    logic  rec_b_valid;

    // Output stage: head register and one overflow register.
    rec_t  head_reg;
    logic  head_v_reg;
    rec_t  ovf_reg;
    logic  ovf_v_reg;

    assign s_tready = !ovf_v_reg && (!head_v_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = head_v_reg && m_tready;

    iop_parse #(
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_fire   (in_fire),
        .opt_byte    (s_tdata[7:0]),
        .area_start  (s_tuser),
        .area_length (s_tdata[13:8]),
        .rec_a       (rec_a),
        .rec_a_valid (rec_a_valid),
        .rec_b       (rec_b),
        .rec_b_valid (rec_b_valid)
    );

    // Output stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
            ovf_v_reg  <= 1'b0;
        end else if (ovf_v_reg) begin
            if (out_fire) begin
                head_v_reg <= 1'b1;
                ovf_v_reg  <= 1'b0;
            end
        end else if (in_fire) begin
            head_v_reg <= rec_a_valid;
            ovf_v_reg  <= rec_b_valid;
        end else if (out_fire) begin
            head_v_reg <= 1'b0;
        end
    end

    // Output stage payload.
    always_ff @(posedge aclk) begin
        if (ovf_v_reg) begin
            if (out_fire) begin
                head_reg <= ovf_reg;
            end
        end else if (in_fire) begin
            head_reg <= rec_a;
            ovf_reg  <= rec_b;
        end
    end

    // Pack the head record onto the result channel.
    assign m_tvalid = head_v_reg;
    assign m_tuser  = head_reg.kind;
    assign m_tlast  = head_reg.last_record;
    assign m_tdata  = {5'd0, head_reg.area_error, head_reg.data_word,
                       head_reg.stamp_flags, head_reg.pointer_value,
                       head_reg.option_length, head_reg.type_code};

endmodule

`default_nettype wire

// ===== tb/sv/iop_checker.sv =====
// ----------------------------------------------------------------------------
// IPv4 option parser checker
// Watches both stream channels of the option parser, predicts the records of
// every accepted option byte and compares them, field by field and in order,
// with the records that leave the block.
// ----------------------------------------------------------------------------
module iop_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // opt_byte [7:0], area_length [13:8], zero pad
    input  logic        s_tuser,    // area_start [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // type_code [7:0], option_length [13:8],
                                    // pointer_value [21:14], stamp_flags [25:22],
                                    // data_word [57:26], area_error [58], zero pad
    input  logic [2:0]  m_tuser,    // record_kind [2:0]
    input  logic        m_tlast,    // last_record
    output int          fail_count,
    output int          records_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import iop_pkg::*;

    // Parser state as the block should hold it.
    logic [5:0]  byte_pos;
    logic [5:0]  area_size;
    phase_t      parse_phase;
    logic [7:0]  cur_type;
    logic [7:0]  cur_len;
    logic [5:0]  opt_start;
    logic [7:0]  cur_ptr;
    logic [3:0]  cur_flags;
    logic [31:0] word_acc;
    logic [1:0]  word_cnt;
    logic        pair_half;
    logic        area_bad;

    // Records of the byte being predicted, and those still owed by the block.
    rec_t        byte_records[$];
    rec_t        expected_records[$];

    initial begin
        fail_count  = 0;
        records_due = 0;
    end

    function automatic void clear_parse_state();
        byte_pos    = '0;
        parse_phase = PH_TYPE;
        cur_type    = '0;
        cur_len     = '0;
        opt_start   = '0;
        cur_ptr     = '0;
        cur_flags   = '0;
        word_acc    = '0;
        word_cnt    = '0;
        pair_half   = 1'b0;
        area_bad    = 1'b0;
    endfunction

    function automatic void add_record(logic [2:0] kind, logic [31:0] data);
        rec_t r;
        r      = '0;
        r.kind = kind;
        // The area done record carries nothing but the error flag.
        if (kind == KIND_DONE) begin
            r.area_error = area_bad;
        end else begin
            r.type_code     = cur_type;
            r.option_length = cur_len[5:0];
            r.pointer_value = cur_ptr;
            r.stamp_flags   = cur_flags;
            r.data_word     = data;
        end
        byte_records.push_back(r);
    endfunction

    function automatic logic is_route(logic [7:0] t);
        return t == OPT_RR || t == OPT_LSRR || t == OPT_SSRR;
    endfunction

    // One byte of a well-started area that has seen no error so far.
    function automatic void parse_option_byte(logic [7:0] b);
        int          pos;
        int          last_pos;
        logic [2:0]  kind;
        pos      = int'(byte_pos);
        last_pos = int'(opt_start) + int'(cur_len) - 1;
        case (parse_phase)
            PH_TYPE: begin
                opt_start = byte_pos;
                cur_type  = b;
                cur_ptr   = '0;
                cur_flags = '0;
                if (b == OPT_EOL || b == OPT_NOP) begin
                    cur_len = 8'd1;
                    add_record(KIND_HEADER, '0);
                end else begin
                    cur_len     = '0;
                    parse_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                cur_len = b;
                if (b < 8'd2 || int'(opt_start) + int'(b) > int'(area_size)) begin
                    area_bad = 1'b1;
                end else if (is_route(cur_type)) begin
                    if (b < 8'd3 || ((int'(b) - 3) % 4) != 0) area_bad = 1'b1;
                    else parse_phase = PH_PTR;
                end else if (cur_type == OPT_TS) begin
                    if (b < 8'd4 || ((int'(b) - 4) % 4) != 0) area_bad = 1'b1;
                    else parse_phase = PH_PTR;
                end else begin
                    add_record(KIND_HEADER, '0);
                    parse_phase = (b == 8'd2) ? PH_TYPE : PH_RAW;
                end
            end
            PH_PTR: begin
                cur_ptr = b;
                if (is_route(cur_type)) begin
                    if ((b % 4) != 0 || b < 8'd4 || int'(b) > int'(cur_len) + 1) begin
                        area_bad = 1'b1;
                    end else begin
                        add_record(KIND_HEADER, '0);
                        word_cnt    = '0;
                        word_acc    = '0;
                        parse_phase = (pos == last_pos) ? PH_TYPE : PH_DATA;
                    end
                end else begin
                    if ((b % 4) != 1 || b < 8'd5 || int'(b) > int'(cur_len) + 1)
                        area_bad = 1'b1;
                    else
                        parse_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                // Reserved flag bits or the undefined low pair end the area.
                if ((b & TS_BAD_FLAGS) != 0 || (b & TS_ADDR_MASK) == 8'd2) begin
                    area_bad = 1'b1;
                end else if ((b & TS_ADDR_MASK) != 0 &&
                             (((int'(cur_len) - 4) % 8) != 0 || (cur_ptr % 8) != 5)) begin
                    area_bad = 1'b1;
                end else begin
                    cur_flags = b[3:0];
                    add_record(KIND_HEADER, '0);
                    pair_half   = 1'b0;
                    word_cnt    = '0;
                    word_acc    = '0;
                    parse_phase = (pos == last_pos) ? PH_TYPE : PH_DATA;
                end
            end
            PH_DATA: begin
                word_acc = {word_acc[23:0], b};
                if (word_cnt == 2'd3) begin
                    if (is_route(cur_type)) begin
                        kind = KIND_ROUTE_ADDR;
                    end else if ((cur_flags & TS_ADDR_MASK[3:0]) != 0) begin
                        kind      = pair_half ? KIND_STAMP : KIND_STAMP_ADDR;
                        pair_half = ~pair_half;
                    end else begin
                        kind = KIND_STAMP;
                    end
                    add_record(kind, word_acc);
                    word_cnt = '0;
                    word_acc = '0;
                end else begin
                    word_cnt = word_cnt + 2'd1;
                end
                if (pos == last_pos) parse_phase = PH_TYPE;
            end
            default: begin
                add_record(KIND_RAW, {24'd0, b});
                if (pos == last_pos) parse_phase = PH_TYPE;
            end
        endcase
    endfunction

    // Works out every record that one accepted byte causes.
    function automatic void predict_records(logic [7:0] b, logic first, logic [5:0] len);
        logic [5:0] n;
        n = len;
        byte_records.delete();
        if (first) begin
            if (n < 6'd1) n = 6'd1;
            if (n > 6'(MAX_OPTION_BYTES)) n = 6'(MAX_OPTION_BYTES);
            clear_parse_state();
            area_size = n;
        end
        // Bytes outside an area are dropped without a record.
        if (byte_pos < area_size) begin
            if (!area_bad) parse_option_byte(b);
            byte_pos = byte_pos + 6'd1;
            if (byte_pos == area_size) begin
                if (parse_phase != PH_TYPE) area_bad = 1'b1;
                add_record(KIND_DONE, '0);
                parse_phase = PH_TYPE;
            end
            if (byte_records.size() > 0) byte_records[$].last_record = 1'b1;
            foreach (byte_records[i]) expected_records.push_back(byte_records[i]);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Records are checked before the byte of the same edge is predicted; a
    // byte never yields a record at the edge that accepts it.
    always @(posedge aclk) begin
        rec_t want;
        if (!aresetn) begin
            clear_parse_state();
            area_size = '0;
            expected_records.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record: kind %0d, tdata 0x%0h", m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_kind", 32'(want.kind), 32'(m_tuser));
                    check_field("type_code", 32'(want.type_code), 32'(m_tdata[7:0]));
                    check_field("option_length", 32'(want.option_length),
                                32'(m_tdata[13:8]));
                    check_field("pointer_value", 32'(want.pointer_value),
                                32'(m_tdata[21:14]));
                    check_field("stamp_flags", 32'(want.stamp_flags), 32'(m_tdata[25:22]));
                    check_field("data_word", want.data_word, m_tdata[57:26]);
                    check_field("area_error", 32'(want.area_error), 32'(m_tdata[58]));
                    check_field("last_record", 32'(want.last_record), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                predict_records(s_tdata[7:0], s_tuser, s_tdata[13:8]);
        end
        records_due = expected_records.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// IPv4 option parser testbench
// Feeds option areas byte by byte, first a directed set of corner cases and
// then random well-formed areas mixed with damaged ones, under several idle
// and back-pressure mixes. The checker beside the block judges every record.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iop_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 38;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // opt_byte [7:0], area_length [13:8], zero pad
    logic        s_tuser  = 1'b0;   // area_start [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // type_code [7:0], option_length [13:8],
                                    // pointer_value [21:14], stamp_flags [25:22],
                                    // data_word [57:26], area_error [58], zero pad
    logic [2:0]  m_tuser;           // record_kind [2:0]
    logic        m_tlast;           // last_record

    int          fail_count;
    int          records_due;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    logic [7:0]  area_bytes[$];

    always #2 aclk = ~aclk;

    ipv4_option_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    iop_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .records_due (records_due)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= stall_pct);
    end

    // Ends the run when no transaction has been seen for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and returns at the
    // falling edge after its transaction. The valid stays high for the next.
    task automatic push_byte(logic [7:0] b, logic first, logic [5:0] len);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom());
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, len, b};
        s_tuser  = first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Sends the first count bytes of the area buffer; the length rides on the
    // first byte only, the later ones carry a random length that is ignored.
    task automatic drive_area(int decl_len, int count);
        for (int i = 0; i < count; i++) begin
            push_byte(area_bytes[i], i == 0,
                      (i == 0) ? 6'(decl_len) : 6'($urandom_range(0, 63)));
        end
    endtask

    // Fills the area buffer with a random sequence of options, valid but for the odd random timestamp flag byte.
    task automatic build_area();
        int         room;
        int         space;
        int         n;
        int         mode;
        logic [7:0] t;
        area_bytes.delete();
        room = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(4, 16);
        do begin
            space = room - area_bytes.size();
            case ($urandom_range(0, 9))
                0, 1: begin
                    area_bytes.push_back($urandom_range(0, 1) ? OPT_NOP : OPT_EOL);
                end
                2, 3, 4: if (space >= 3) begin
                    case ($urandom_range(0, 2))
                        0:       t = OPT_RR;
                        1:       t = OPT_LSRR;
                        default: t = OPT_SSRR;
                    endcase
                    n = $urandom_range(0, ((space - 3) / 4 < 4) ? (space - 3) / 4 : 4);
                    area_bytes.push_back(t);
                    area_bytes.push_back(8'(3 + 4 * n));
                    area_bytes.push_back(8'(4 + 4 * $urandom_range(0, n)));
                    repeat (4 * n) area_bytes.push_back(8'($urandom()));
                end
                5, 6: if (space >= 4) begin
                    mode = $urandom_range(0, 3);
                    area_bytes.push_back(OPT_TS);
                    if (mode == 0 && space >= 12) begin
                        // Address and timestamp pairs, flag 1 or 3.
                        n = $urandom_range(0, ((space - 4) / 8 < 2) ? (space - 4) / 8 : 2);
                        area_bytes.push_back(8'(4 + 8 * n));
                        area_bytes.push_back(8'(5 + 8 * $urandom_range(0, n)));
                        area_bytes.push_back({4'($urandom()), 2'b00,
                                              $urandom_range(0, 1) ? 2'd3 : 2'd1});
                        repeat (8 * n) area_bytes.push_back(8'($urandom()));
                    end else begin
                        // Timestamps only; now and then a random flag byte.
                        n = $urandom_range(0, ((space - 4) / 4 < 4) ? (space - 4) / 4 : 4);
                        area_bytes.push_back(8'(4 + 4 * n));
                        area_bytes.push_back(8'(5 + 4 * $urandom_range(0, n)));
                        area_bytes.push_back((mode == 1) ? 8'($urandom())
                                                         : {4'($urandom()), 4'd0});
                        repeat (4 * n) area_bytes.push_back(8'($urandom()));
                    end
                end
                default: if (space >= 2) begin
                    t = 8'($urandom());
                    while (t == OPT_EOL || t == OPT_NOP || t == OPT_RR || t == OPT_TS ||
                           t == OPT_LSRR || t == OPT_SSRR)
                        t = 8'($urandom());
                    n = $urandom_range(0, (space - 2 < 4) ? space - 2 : 4);
                    area_bytes.push_back(t);
                    area_bytes.push_back(8'(2 + n));
                    repeat (n) area_bytes.push_back(8'($urandom()));
                end
            endcase
        end while (area_bytes.size() < room && $urandom_range(0, 3) != 0);
        if (area_bytes.size() == 0) area_bytes.push_back(OPT_NOP);
    endtask

    // One random area, damaged in about a third of the cases.
    task automatic run_random_area();
        int decl_len;
        int count;
        build_area();
        decl_len = area_bytes.size();
        count    = area_bytes.size();
        case ($urandom_range(0, 11))
            0: area_bytes[$urandom_range(0, count - 1)] = 8'($urandom());
            1: decl_len = $urandom_range(0, 63);
            2: count = $urandom_range(1, count);
            3: begin
                repeat ($urandom_range(1, 3)) area_bytes.push_back(8'($urandom()));
                count = area_bytes.size();
            end
            default: ;
        endcase
        drive_area(decl_len, count);
    endtask

    initial begin
        int target;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed corner cases, no idling.
        // A byte before any area has started is dropped.
        push_byte(8'hFF, 1'b0, 6'd63);
        // A zero length is raised to one byte.
        area_bytes = '{OPT_EOL};
        drive_area(0, 1);
        // The longest length is cut to the maximum; record route, then a
        // timestamp with address pairs and a set overflow count. The next
        // area start abandons this one before its end.
        area_bytes = '{OPT_RR, 8'd7, 8'd4, 8'hC0, 8'hA8, 8'h00, 8'hFF,
                       OPT_TS, 8'd12, 8'd5, 8'h31, 8'h0A, 8'h00, 8'h00, 8'h01,
                       8'hFF, 8'hFF, 8'hFF, 8'hFE};
        drive_area(63, area_bytes.size());
        // Timestamp flags with the undefined low pair, then with a reserved bit.
        area_bytes = '{OPT_TS, 8'd4, 8'd5, 8'h02};
        drive_area(4, 4);
        area_bytes = '{OPT_TS, 8'd4, 8'd5, 8'h08};
        drive_area(4, 4);
        // A raw option, then a type byte cut off by the end of the area.
        area_bytes = '{OPT_NOP, 8'hFE, 8'd3, 8'hA5, OPT_SSRR};
        drive_area(5, 5);
        // A byte after the area is done is dropped.
        push_byte(8'h00, 1'b0, 6'd0);

        // Random areas under four idle and back-pressure mixes.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 55; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) run_random_area();
        end

        s_tvalid = 1'b0;
        while (records_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
